// ----- src/reader_writer_lock_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Reader-writer lock unit assertion macros
// Concurrent assertion wrappers that fall away in synthesis.
// ----------------------------------------------------------------------------
`ifndef READER_WRITER_LOCK_UNIT_MACROS_SVH
`define READER_WRITER_LOCK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define RWL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// When the trigger holds, the consequence must hold in the next cycle.
`define RWL_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
    else $error(msg);
`else
`define RWL_ASSERT(lbl, clk, rst_n, prop, msg)
`define RWL_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)
`endif

`endif

// ----- src/rwl_pkg.sv -----
// ----------------------------------------------------------------------------
// Reader-writer lock unit package
// Request kinds, status codes and counter widths shared by the lock unit.
// ----------------------------------------------------------------------------
package rwl_pkg;

  localparam int unsigned CountBits    = 8;
  localparam int unsigned TidW         = 6;
  localparam int unsigned KindW        = 3;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned ReaderTotalW = 8;

  typedef logic [CountBits-1:0] count_t;
  typedef logic [TidW-1:0]      tid_t;

  localparam count_t CountMax = '1;

  typedef enum logic [KindW-1:0] {
    REQ_RDLOCK      = 3'd0,
    REQ_TRYRDLOCK   = 3'd1,
    REQ_WRLOCK      = 3'd2,
    REQ_TRYWRLOCK   = 3'd3,
    REQ_UNLOCK      = 3'd4,
    REQ_RD_RESUMED  = 3'd5,
    REQ_WR_RESUMED  = 3'd6
  } req_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED   = 3'd0,
    ST_WAIT      = 3'd1,
    ST_BUSY      = 3'd2,
    ST_AGAIN     = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_NO_WAITER = 3'd5
  } status_e;

endpackage

// ----- src/reader_writer_lock_unit.sv -----
// ----------------------------------------------------------------------------
// Reader-writer lock unit
// Writer-preferring lock arbiter with waiting counts and wake hints.
// ----------------------------------------------------------------------------
// The unit takes one lock transaction per clock cycle while the consumer keeps
// up and returns exactly one response transaction for each, in order. A request
// is captured in an input register; from there a single pass of compare and
// increment logic evaluates it against the lock state, updates that state and
// loads the response register, from which the response is presented, so the
// sustained rate is one transaction per cycle. Both registers advance together
// whenever the response register is empty or being taken, so a full pipeline
// keeps accepting while the consumer keeps up and holds cleanly when
// it stalls. New readers are admitted only while no writer holds the lock and
// none waits; a writer is admitted only when there are neither readers nor a
// writer. Blocking requests that cannot be granted are counted as waiting and
// answered with a wait status; try requests are answered busy instead. All
// counters saturate: a request that would overflow one changes nothing and is
// answered with an again status. A successful unlock hints that one waiting
// writer should be woken when no readers remain, otherwise that all waiting
// readers should be woken. The scheduler reports each woken thread back with
// a resumed-reader or resumed-writer transaction. The state is cleared by
// reset, so the lock is usable at once after reset.
// ----------------------------------------------------------------------------
`include "reader_writer_lock_unit_macros.svh"

module reader_writer_lock_unit
  import rwl_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Request channel
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  logic [KindW-1:0]        req_type_i,
  input  logic [TidW-1:0]         thread_id_i,
  // Response channel
  output logic                    rsp_valid_o,
  input  logic                    rsp_ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic                    wake_one_writer_o,
  output logic                    wake_all_readers_o,
  output logic [ReaderTotalW-1:0] reader_total_o
);

  // --------------------------------------------------------------------------
  // Pipeline control. The evaluate stage fires when it holds a request and the
  // response register is free or is being emptied in this cycle.
  // --------------------------------------------------------------------------
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic eval_fire;

  assign advance     = !out_valid_q || rsp_ready_i;
  assign eval_fire   = in_valid_q && advance;
  assign req_ready_o = !in_valid_q || advance;

  // Input register (payload needs no reset)
  logic [KindW-1:0] kind_q;
  tid_t             tid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      in_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      kind_q <= req_type_i;
      tid_q  <= thread_id_i;
    end
  end

  // --------------------------------------------------------------------------
  // Lock state
  // --------------------------------------------------------------------------
  count_t active_readers_q, active_readers_d;
  count_t readers_waiting_q, readers_waiting_d;
  count_t writers_waiting_q, writers_waiting_d;
  logic   writer_held_q, writer_held_d;
  tid_t   writer_owner_q, writer_owner_d;

  status_e status_d;
  logic    wake_w_d;
  logic    wake_r_d;

  // --------------------------------------------------------------------------
  // Single-pass evaluation of the captured request against the lock state.
  // --------------------------------------------------------------------------
  always_comb begin
    active_readers_d  = active_readers_q;
    readers_waiting_d = readers_waiting_q;
    writers_waiting_d = writers_waiting_q;
    writer_held_d     = writer_held_q;
    writer_owner_d    = writer_owner_q;
    status_d          = ST_GRANTED;
    wake_w_d          = 1'b0;
    wake_r_d          = 1'b0;

    unique case (kind_q)
      REQ_RDLOCK, REQ_TRYRDLOCK: begin
        if (!writer_held_q && (writers_waiting_q == '0)) begin
          if (active_readers_q == CountMax) begin
            status_d = ST_AGAIN;
          end else begin
            active_readers_d = active_readers_q + count_t'(1);
          end
        end else if (kind_q == REQ_TRYRDLOCK) begin
          status_d = ST_BUSY;
        end else if (readers_waiting_q == CountMax) begin
          status_d = ST_AGAIN;
        end else begin
          readers_waiting_d = readers_waiting_q + count_t'(1);
          status_d          = ST_WAIT;
        end
      end
      REQ_WRLOCK, REQ_TRYWRLOCK: begin
        if (!writer_held_q && (active_readers_q == '0)) begin
          writer_owner_d = tid_q;
          writer_held_d  = 1'b1;
        end else if (kind_q == REQ_TRYWRLOCK) begin
          status_d = ST_BUSY;
        end else if (writers_waiting_q == CountMax) begin
          status_d = ST_AGAIN;
        end else begin
          writers_waiting_d = writers_waiting_q + count_t'(1);
          status_d          = ST_WAIT;
        end
      end
      REQ_UNLOCK: begin
        if (writer_held_q && (writer_owner_q != tid_q)) begin
          status_d = ST_NOT_OWNER;
        end else begin
          if (writer_held_q) begin
            writer_held_d = 1'b0;
          end else if (active_readers_q != '0) begin
            active_readers_d = active_readers_q - count_t'(1);
          end
          // The wake decision looks at the reader count after this release.
          if ((active_readers_d == '0) && (writers_waiting_q != '0)) begin
            wake_w_d = 1'b1;
          end else if (readers_waiting_q != '0) begin
            wake_r_d = 1'b1;
          end
        end
      end
      REQ_RD_RESUMED: begin
        if (readers_waiting_q == '0) begin
          status_d = ST_NO_WAITER;
        end else if (active_readers_q == CountMax) begin
          status_d = ST_AGAIN;
        end else begin
          active_readers_d  = active_readers_q + count_t'(1);
          readers_waiting_d = readers_waiting_q - count_t'(1);
        end
      end
      REQ_WR_RESUMED: begin
        if (writers_waiting_q == '0) begin
          status_d = ST_NO_WAITER;
        end else begin
          writer_owner_d    = tid_q;
          writer_held_d     = 1'b1;
          writers_waiting_d = writers_waiting_q - count_t'(1);
        end
      end
      default: begin
        // Unused request kind: no effect on the lock.
        status_d = ST_NO_WAITER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_readers_q  <= '0;
      readers_waiting_q <= '0;
      writers_waiting_q <= '0;
      writer_held_q     <= 1'b0;
      writer_owner_q    <= '0;
    end else if (eval_fire) begin
      active_readers_q  <= active_readers_d;
      readers_waiting_q <= readers_waiting_d;
      writers_waiting_q <= writers_waiting_d;
      writer_held_q     <= writer_held_d;
      writer_owner_q    <= writer_owner_d;
    end
  end

  // --------------------------------------------------------------------------
  // Response register. The reported reader total is the low bits of the
  // updated count, zero-extended when the counter is narrower.
  // --------------------------------------------------------------------------
  logic [CountBits+ReaderTotalW-1:0] total_ext;
  assign total_ext = {{ReaderTotalW{1'b0}}, active_readers_d};

  status_e                 status_q;
  logic                    wake_w_q;
  logic                    wake_r_q;
  logic [ReaderTotalW-1:0] reader_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      status_q       <= status_d;
      wake_w_q       <= wake_w_d;
      wake_r_q       <= wake_r_d;
      reader_total_q <= total_ext[ReaderTotalW-1:0];
    end
  end

  assign rsp_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign wake_one_writer_o  = wake_w_q;
  assign wake_all_readers_o = wake_r_q;
  assign reader_total_o     = reader_total_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RWL_ASSERT(a_wake_exclusive, clk_i, rst_ni,
      !(out_valid_q && wake_w_q && wake_r_q),
      "both wake hints raised in one response")

  `RWL_ASSERT(a_wake_only_granted, clk_i, rst_ni,
      !(out_valid_q && (wake_w_q || wake_r_q) && (status_q != ST_GRANTED)),
      "wake hint on a response that was not granted")

  `RWL_ASSERT_NEXT(a_state_holds_when_idle, clk_i, rst_ni, !eval_fire,
      $stable(active_readers_q) && $stable(readers_waiting_q) &&
      $stable(writers_waiting_q) && $stable(writer_held_q),
      "lock state changed without an evaluated transaction")

  `RWL_ASSERT_NEXT(a_writer_gain_source, clk_i, rst_ni,
      eval_fire && !writer_held_q && writer_held_d,
      writer_held_q && out_valid_q && (status_q == ST_GRANTED),
      "writer ownership taken without a granted response")

  `RWL_ASSERT_NEXT(a_response_follows_eval, clk_i, rst_ni, eval_fire,
      out_valid_q,
      "evaluated transaction produced no response")

endmodule
